>>> rtl/ssff_pkg.sv
package ssff_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_TIME = 2'd0,
    REQ_INT  = 2'd1,
    REQ_ERR  = 2'd2,
    REQ_CHAR = 2'd3
  } req_kind_e;

  // Source that a display lane draws its pattern from.
  typedef enum logic [1:0] {
    SRC_FIXED = 2'd0,
    SRC_DIGIT = 2'd1,
    SRC_CHAR  = 2'd2
  } lane_src_e;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned SegW      = 7;

  // Fixed segment patterns, G in bit 6 and A in bit 0.
  localparam logic [SegW-1:0] SEG_BLANK = 7'h00;
  localparam logic [SegW-1:0] SEG_COLON = 7'h48;
  localparam logic [SegW-1:0] SEG_E     = 7'h79;
  localparam logic [SegW-1:0] SEG_R_LOW = 7'h50;

  // What one lane is told to show.
  typedef struct packed {
    lane_src_e       src;
    logic [3:0]      digit;
    logic [7:0]      code;
    logic [SegW-1:0] fixed;
  } lane_ctl_t;

  // Item after the arithmetic split: two pairs of decimal digits and one single digit.
  typedef struct packed {
    req_kind_e       kind;
    logic            blank1;
    logic            colon;
    logic            green;
    logic            red;
    logic            err_big;
    logic [4:0][7:0] chars;
    logic [2:0]      d1;
    logic [6:0]      px;
    logic [6:0]      py;
  } s2_t;

endpackage

>>> rtl/ssff_decomp.sv
module ssff_decomp
  import ssff_pkg::*;
(
  input  logic            clk_i,
  input  logic            en1_i,
  input  logic            en2_i,
  input  req_kind_e       kind_i,
  input  logic [16:0]     value_i,
  input  logic [4:0][7:0] chars_i,
  input  logic            colon_i,
  input  logic            green_i,
  input  logic            red_i,
  input  logic            fmt24_i,
  output s2_t             s2_o
);

  // Reciprocals, exact over the saturated input ranges.
  localparam logic [16:0] RecipHour  = 17'd37283;   // 2^27 / 3600
  localparam logic [16:0] RecipC100  = 17'd83887;   // 2^23 / 100
  localparam logic [17:0] RecipMin   = 18'd139811;  // 2^23 / 60
  localparam logic [17:0] RecipC10k  = 18'd107375;  // 2^30 / 10000
  localparam logic [16:0] SecMax     = 17'd86399;
  localparam logic [16:0] IntMax     = 17'd65535;
  localparam logic [16:0] ErrMax     = 17'd99;

  typedef struct packed {
    req_kind_e       kind;
    logic            fmt24;
    logic            colon;
    logic            green;
    logic            red;
    logic            err_big;
    logic [4:0][7:0] chars;
    logic [6:0]      e;
    logic [15:0]     n;
    logic [9:0]      qa;
    logic [10:0]     qb;
  } s1_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;

  logic [16:0] sec_sat;
  logic [15:0] int_sat;
  logic [16:0] op_a, op_b;
  logic [16:0] k_a;
  logic [17:0] k_b;
  logic [33:0] prod_a;
  logic [34:0] prod_b;
  logic        is_time;

  // Stage one: saturate and divide by reciprocal multiplication.
  always_comb begin
    is_time = (kind_i == REQ_TIME);
    sec_sat = (value_i > SecMax) ? SecMax : value_i;
    int_sat = (value_i > IntMax) ? 16'hFFFF : value_i[15:0];
    op_a    = is_time ? sec_sat : {1'b0, int_sat};
    op_b    = op_a;
    k_a     = is_time ? RecipHour : RecipC100;
    k_b     = is_time ? RecipMin : RecipC10k;
    prod_a  = 34'(op_a) * 34'(k_a);
    prod_b  = 35'(op_b) * 35'(k_b);

    s1_d.kind    = kind_i;
    s1_d.fmt24   = fmt24_i;
    s1_d.colon   = colon_i;
    s1_d.green   = green_i;
    s1_d.red     = red_i;
    s1_d.err_big = (value_i > ErrMax);
    s1_d.chars   = chars_i;
    s1_d.e       = value_i[6:0];
    s1_d.n       = int_sat;
    // Hours or n/100 from the first product, minutes of day or n/10000 from the second.
    s1_d.qa      = is_time ? {5'd0, prod_a[31:27]} : prod_a[32:23];
    s1_d.qb      = is_time ? prod_b[33:23] : {8'd0, prod_b[32:30]};
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      s1_q <= s1_d;
    end
  end

  logic [4:0]  hr;
  logic [4:0]  hr_disp;
  logic [10:0] hr60;
  logic [9:0]  hd100;
  logic [15:0] hi100;

  // Stage two: remainders by subtraction and the 12-hour adjustment.
  always_comb begin
    hr    = s1_q.qa[4:0];
    hr60  = {hr, 6'd0} - {4'd0, hr, 2'd0};
    hd100 = 10'(s1_q.qb[2:0]) * 10'd100;
    hi100 = 16'(s1_q.qa) * 16'd100;

    hr_disp = hr;
    if (!s1_q.fmt24) begin
      if (hr == 5'd0) begin
        hr_disp = 5'd12;
      end else if (hr > 5'd12) begin
        hr_disp = hr - 5'd12;
      end
    end

    s2_d.kind    = s1_q.kind;
    s2_d.blank1  = !s1_q.fmt24 && (hr_disp < 5'd10);
    s2_d.colon   = s1_q.colon;
    s2_d.green   = s1_q.green;
    s2_d.red     = s1_q.red;
    s2_d.err_big = s1_q.err_big;
    s2_d.chars   = s1_q.chars;
    s2_d.d1      = s1_q.qb[2:0];
    s2_d.px      = 7'(s1_q.qa - hd100);
    s2_d.py      = 7'(s1_q.n - hi100);

    unique case (s1_q.kind)
      REQ_TIME: begin
        s2_d.px = {2'd0, hr_disp};
        s2_d.py = {1'b0, 6'(s1_q.qb - hr60)};
      end
      REQ_ERR: begin
        s2_d.py = s1_q.e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

>>> rtl/ssff_lane.sv
module ssff_lane
  import ssff_pkg::*;
(
  input  lane_ctl_t       ctl_i,
  output logic [SegW-1:0] seg_o
);

  localparam logic [9:0][SegW-1:0] DigitSegs = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };
  localparam logic [25:0][SegW-1:0] UpperSegs = {
    7'h5B, 7'h6A, 7'h49, 7'h1D, 7'h2E, 7'h3E, 7'h31, 7'h6D, 7'h7B, 7'h6B,
    7'h73, 7'h3F, 7'h37, 7'h2B, 7'h38, 7'h75, 7'h1E, 7'h30, 7'h76, 7'h3D,
    7'h71, 7'h79, 7'h1F, 7'h39, 7'h7F, 7'h77
  };
  localparam logic [25:0][SegW-1:0] LowerSegs = {
    7'h48, 7'h6E, 7'h48, 7'h2A, 7'h0C, 7'h1C, 7'h78, 7'h0C, 7'h50, 7'h47,
    7'h73, 7'h5C, 7'h54, 7'h55, 7'h30, 7'h69, 7'h0D, 7'h19, 7'h74, 7'h59,
    7'h70, 7'h18, 7'h5E, 7'h58, 7'h7C, 7'h4C
  };

  function automatic logic [SegW-1:0] digit_segs(input logic [3:0] d);
    logic [SegW-1:0] s;
    s = SEG_BLANK;
    if (d <= 4'd9) begin
      s = DigitSegs[d];
    end
    return s;
  endfunction

  function automatic logic [SegW-1:0] char_segs(input logic [7:0] c);
    logic [7:0]      off_num;
    logic [7:0]      off_up;
    logic [7:0]      off_lo;
    logic [SegW-1:0] s;
    off_num = c - 8'h30;
    off_up  = c - 8'h41;
    off_lo  = c - 8'h61;
    s       = SEG_BLANK;
    // Raw values 0 to 9 and the ASCII digits both show digits.
    if (c <= 8'd9) begin
      s = digit_segs(c[3:0]);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = digit_segs(off_num[3:0]);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = UpperSegs[off_up[4:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = LowerSegs[off_lo[4:0]];
    end else begin
      unique case (c)
        8'h22:                s = 7'h22;  // double quote
        8'h27:                s = 7'h20;  // apostrophe
        8'h3A, 8'h3B, 8'h3D:  s = 7'h48;  // colon, semicolon, equals
        8'h2D:                s = 7'h40;  // minus
        8'h5F:                s = 7'h08;  // underscore
        8'h28:                s = 7'h39;  // open bracket
        8'h29:                s = 7'h0F;  // close bracket
        8'h2A:                s = 7'h63;  // asterisk
        default:              s = SEG_BLANK;
      endcase
    end
    return s;
  endfunction

  // Pattern lookup for one display position.
  always_comb begin
    unique case (ctl_i.src)
      SRC_FIXED: seg_o = ctl_i.fixed;
      SRC_DIGIT: seg_o = digit_segs(ctl_i.digit);
      SRC_CHAR:  seg_o = char_segs(ctl_i.code);
      default:   seg_o = SEG_BLANK;
    endcase
  end

endmodule

>>> rtl/ssff_merge.sv
module ssff_merge
  import ssff_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [NumDigits-1:0][SegW-1:0] seg_i,
  input  logic                          green_i,
  input  logic                          red_i,
  input  logic                          shown_i,
  output logic [39:0]                   tdata_o,
  output logic                          tuser_o
);

  logic [39:0] tdata_d, tdata_q;
  logic        tuser_q;

  // Pack the five lane patterns and the indicators into one frame.
  always_comb begin
    tdata_d = {3'd0, red_i, green_i, seg_i[4], seg_i[3], seg_i[2], seg_i[1], seg_i[0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tdata_q <= tdata_d;
      tuser_q <= shown_i;
    end
  end

  assign tdata_o = tdata_q;
  assign tuser_o = tuser_q;

endmodule

>>> rtl/seven_segment_frame_formatter.sv
// Seven-segment frame formatter.
// Input channel s_axis: one request per item, the kind in tuser (time, integer,
// error code, characters) and the value, five character codes and the colon
// and indicator requests in tdata.
// Output channel m_axis: one frame per request, five segment patterns and the
// green and red indicators in tdata, and in tuser a flag that is low when an
// error code above 99 leaves the display as it was.
// The 24-hour/12-hour choice is to be written through cfg_we_i and cfg_wdata_i
// only while no request is in flight; the block itself does not enforce this.
// A request passes through a multiply stage, a remainder stage, a digit
// routing stage and the output register that holds the lane outputs. One item
// is accepted in every cycle unless a stall at m_axis_tready holds the stages.
// After reset the pipeline is empty and the display runs in 24-hour form.
// When the receiver holds m_axis_tready low the stages fill up behind the
// output register and s_axis_tready falls once all four hold an item.
module seven_segment_frame_formatter
  import ssff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // hour_format_24
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // value[16:0], char1[24:17], char2[32:25], char3[40:33], char4[48:41],
  // char5[56:49], colon_req[57], green_in[58], red_in[59], zero[63:60]
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,     // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seg1[6:0], seg2[13:7], seg3[20:14], seg4[27:21], seg5[34:28],
  // green_led[35], red_led[36], zero[39:37]
  output logic [39:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser      // shown[0]
);

  logic hf24_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  // Hour format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf24_q <= 1'b1;
    end else if (cfg_we_i) begin
      hf24_q <= cfg_wdata_i;
    end
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  assign adv4 = !v4_q || m_axis_tready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  assign s_axis_tready = adv1;
  assign m_axis_tvalid = v4_q;

  s2_t             s2;
  logic [4:0][7:0] chars_in;

  assign chars_in = s_axis_tdata[56:17];

  ssff_decomp u_decomp (
    .clk_i   (clk_i),
    .en1_i   (adv1),
    .en2_i   (adv2),
    .kind_i  (req_kind_e'(s_axis_tuser)),
    .value_i (s_axis_tdata[16:0]),
    .chars_i (chars_in),
    .colon_i (s_axis_tdata[57]),
    .green_i (s_axis_tdata[58]),
    .red_i   (s_axis_tdata[59]),
    .fmt24_i (hf24_q),
    .s2_o    (s2)
  );

  // Tens of a value below 100.
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] t;
    t = 4'd0;
    for (int unsigned i = 1; i <= 9; i++) begin
      if (x >= 7'(i * 10)) begin
        t = 4'(i);
      end
    end
    return t;
  endfunction

  function automatic lane_ctl_t digit_ctl(input logic [3:0] d);
    lane_ctl_t c;
    c.src   = SRC_DIGIT;
    c.digit = d;
    c.code  = 8'd0;
    c.fixed = SEG_BLANK;
    return c;
  endfunction

  function automatic lane_ctl_t fixed_ctl(input logic [SegW-1:0] s);
    lane_ctl_t c;
    c.src   = SRC_FIXED;
    c.digit = 4'd0;
    c.code  = 8'd0;
    c.fixed = s;
    return c;
  endfunction

  lane_ctl_t [NumDigits-1:0] ctl_d, ctl_q;
  logic       green_d, red_d, shown_d;
  logic       green_q, red_q, shown_q;
  logic [3:0] px_t, px_o, py_t, py_o;

  // Split the digit pairs and route each position to its lane.
  always_comb begin
    px_t = tens_of(s2.px);
    px_o = 4'(s2.px - 7'(px_t) * 7'd10);
    py_t = tens_of(s2.py);
    py_o = 4'(s2.py - 7'(py_t) * 7'd10);

    for (int unsigned k = 0; k < NumDigits; k++) begin
      ctl_d[k] = fixed_ctl(SEG_BLANK);
    end
    green_d = 1'b0;
    red_d   = 1'b0;
    shown_d = 1'b1;

    unique case (s2.kind)
      REQ_TIME: begin
        ctl_d[0] = s2.blank1 ? fixed_ctl(SEG_BLANK) : digit_ctl(px_t);
        ctl_d[1] = digit_ctl(px_o);
        ctl_d[2] = fixed_ctl(s2.colon ? SEG_COLON : SEG_BLANK);
        ctl_d[3] = digit_ctl(py_t);
        ctl_d[4] = digit_ctl(py_o);
      end
      REQ_INT: begin
        ctl_d[0] = digit_ctl({1'b0, s2.d1});
        ctl_d[1] = digit_ctl(px_t);
        ctl_d[2] = digit_ctl(px_o);
        ctl_d[3] = digit_ctl(py_t);
        ctl_d[4] = digit_ctl(py_o);
        green_d  = s2.green;
        red_d    = s2.red;
      end
      REQ_ERR: begin
        if (s2.err_big) begin
          shown_d = 1'b0;
        end else begin
          ctl_d[0] = fixed_ctl(SEG_E);
          ctl_d[1] = fixed_ctl(SEG_R_LOW);
          ctl_d[2] = fixed_ctl(SEG_R_LOW);
          ctl_d[3] = digit_ctl(py_t);
          ctl_d[4] = digit_ctl(py_o);
          red_d    = 1'b1;
        end
      end
      REQ_CHAR: begin
        for (int unsigned k = 0; k < NumDigits; k++) begin
          ctl_d[k].src  = SRC_CHAR;
          ctl_d[k].code = s2.chars[k];
        end
        green_d = s2.green;
        red_d   = s2.red;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ctl_q   <= ctl_d;
      green_q <= green_d;
      red_q   <= red_d;
      shown_q <= shown_d;
    end
  end

  // One lookup lane per display position.
  logic [NumDigits-1:0][SegW-1:0] seg;

  for (genvar g = 0; g < NumDigits; g++) begin : g_lane
    ssff_lane u_lane (
      .ctl_i (ctl_q[g]),
      .seg_o (seg[g])
    );
  end

  ssff_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (adv4),
    .seg_i   (seg),
    .green_i (green_q),
    .red_i   (red_q),
    .shown_i (shown_q),
    .tdata_o (m_axis_tdata),
    .tuser_o (m_axis_tuser[0])
  );

endmodule

>>> tb/sv/ssff_frame_checker.sv
// Watches both channels of the seven-segment frame formatter, works out the
// frame that each accepted request should give and compares it, field by
// field, with the frames that leave the block in order.
module ssff_frame_checker
  import ssff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  // One display frame; segs[0] is the leftmost digit.
  typedef struct packed {
    logic [4:0][6:0] segs;
    logic            green;
    logic            red;
    logic            shown;
  } frame_t;

  frame_t frames_due[$];
  frame_t want;
  frame_t got;
  logic   hour24;
  int     errors = 0;
  int     i;

  assign fail_count_o = errors;

  // Segment pattern of a decimal digit, G in bit 6; anything above 9 is blank.
  function automatic logic [6:0] digit_glyph(int unsigned d);
    case (d)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      9: return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // Segment pattern of a character code. The letter tables keep G..A in
  // bits 7..1, so the pattern is the top seven bits.
  function automatic logic [6:0] char_glyph(logic [7:0] c);
    logic [7:0] raw;
    raw = 8'h00;
    if (c <= 8'd9) return digit_glyph(c);
    if (c >= 8'h30 && c <= 8'h39) return digit_glyph(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h5A) begin
      case (c - 8'h41)
        0: raw = 8'hEE;  1: raw = 8'hFE;  2: raw = 8'h72;  3: raw = 8'h3E;
        4: raw = 8'hF2;  5: raw = 8'hE2;  6: raw = 8'h7A;  7: raw = 8'hEC;
        8: raw = 8'h60;  9: raw = 8'h3C;  10: raw = 8'hEA; 11: raw = 8'h70;
        12: raw = 8'h56; 13: raw = 8'h6E; 14: raw = 8'h7E; 15: raw = 8'hE6;
        16: raw = 8'hD6; 17: raw = 8'hF6; 18: raw = 8'hDA; 19: raw = 8'h62;
        20: raw = 8'h7C; 21: raw = 8'h5C; 22: raw = 8'h3A; 23: raw = 8'h92;
        24: raw = 8'hD4; default: raw = 8'hB6;
      endcase
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      case (c - 8'h61)
        0: raw = 8'h98;  1: raw = 8'hF8;  2: raw = 8'hB0;  3: raw = 8'hBC;
        4: raw = 8'h30;  5: raw = 8'hE0;  6: raw = 8'hB2;  7: raw = 8'hE8;
        8: raw = 8'h32;  9: raw = 8'h1A;  10: raw = 8'hD2; 11: raw = 8'h60;
        12: raw = 8'hAA; 13: raw = 8'hA8; 14: raw = 8'hB8; 15: raw = 8'hE6;
        16: raw = 8'h8E; 17: raw = 8'hA0; 18: raw = 8'h18; 19: raw = 8'hF0;
        20: raw = 8'h38; 21: raw = 8'h18; 22: raw = 8'h54; 23: raw = 8'h90;
        24: raw = 8'hDC; default: raw = 8'h90;
      endcase
    end else begin
      case (c)
        8'h22: raw = 8'h44;
        8'h27: raw = 8'h40;
        8'h3A, 8'h3B, 8'h3D: raw = 8'h90;
        8'h2D: raw = 8'h80;
        8'h5F: raw = 8'h10;
        8'h28: raw = 8'h72;
        8'h29: raw = 8'h1E;
        8'h2A: raw = 8'hC6;
        default: raw = 8'h00;
      endcase
    end
    return raw[7:1];
  endfunction

  // The frame that one request should produce under the current hour form.
  function automatic frame_t frame_for(req_kind_e kind, logic [16:0] value,
                                       logic [4:0][7:0] chars, logic colon,
                                       logic green, logic red, logic h24);
    frame_t      f;
    int unsigned s, hr, mn, n;
    f = '0;
    f.shown = 1'b1;
    case (kind)
      REQ_TIME: begin
        s  = (value > 17'd86399) ? 86399 : value;
        hr = s / 3600;
        mn = s / 60 - 60 * hr;
        if (!h24) begin
          if (hr == 0) hr = 12;
          if (hr > 12) hr = hr - 12;
        end
        // In 12-hour form a leading zero on the hour is blanked.
        f.segs[0] = (!h24 && hr / 10 == 0) ? SEG_BLANK : digit_glyph(hr / 10);
        f.segs[1] = digit_glyph(hr % 10);
        f.segs[2] = colon ? SEG_COLON : SEG_BLANK;
        f.segs[3] = digit_glyph(mn / 10);
        f.segs[4] = digit_glyph(mn % 10);
      end
      REQ_INT: begin
        n = (value > 17'd65535) ? 65535 : value;
        f.segs[0] = digit_glyph(n / 10000);
        f.segs[1] = digit_glyph((n / 1000) % 10);
        f.segs[2] = digit_glyph((n / 100) % 10);
        f.segs[3] = digit_glyph((n / 10) % 10);
        f.segs[4] = digit_glyph(n % 10);
        f.green   = green;
        f.red     = red;
      end
      REQ_ERR: begin
        // Codes above 99 leave the display as it was: the whole frame is zero.
        if (value > 17'd99) begin
          f.shown = 1'b0;
        end else begin
          f.segs[0] = SEG_E;
          f.segs[1] = SEG_R_LOW;
          f.segs[2] = SEG_R_LOW;
          f.segs[3] = digit_glyph(value / 10);
          f.segs[4] = digit_glyph(value % 10);
          f.red     = 1'b1;
        end
      end
      default: begin
        for (int k = 0; k < 5; k++) f.segs[k] = char_glyph(chars[k]);
        f.green = green;
        f.red   = red;
      end
    endcase
    return f;
  endfunction

  // Frames leave first, then the request taken at this edge is queued, so a
  // frame is never matched against the item accepted in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour24 <= 1'b1;
      frames_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) hour24 <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.segs  = m_axis_tdata[34:0];
        got.green = m_axis_tdata[35];
        got.red   = m_axis_tdata[36];
        got.shown = m_axis_tuser[0];
        if (frames_due.size() == 0) begin
          $error("frame %h/%b arrived with no request waiting", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = frames_due.pop_front();
          for (i = 0; i < 5; i++) begin
            if (got.segs[i] !== want.segs[i]) begin
              $error("seg%0d: expected %h, got %h", i + 1, want.segs[i], got.segs[i]);
              errors++;
            end
          end
          if (got.green !== want.green) begin
            $error("green_led: expected %b, got %b", want.green, got.green);
            errors++;
          end
          if (got.red !== want.red) begin
            $error("red_led: expected %b, got %b", want.red, got.red);
            errors++;
          end
          if (got.shown !== want.shown) begin
            $error("shown: expected %b, got %b", want.shown, got.shown);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        frames_due.push_back(frame_for(req_kind_e'(s_axis_tuser), s_axis_tdata[16:0],
                                       s_axis_tdata[56:17], s_axis_tdata[57],
                                       s_axis_tdata[58], s_axis_tdata[59], hour24));
      end
      pending_o <= frames_due.size();
    end
  end

endmodule

>>> tb/sv/seven_segment_frame_formatter_tb.sv
// Drives requests into the frame formatter with random gaps and stalls; the
// checker beside the block does the prediction and comparison.
module seven_segment_frame_formatter_tb;
  import ssff_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int fail_count;
  int pending;

  // Steady stretches run both sides without idling; hold_now asks the
  // receiver for one long hold-off.
  logic steady = 1'b0;
  logic hold_now = 1'b0;

  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 275;
  localparam int LongHold     = 200;

  seven_segment_frame_formatter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ssff_frame_checker frame_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Character codes, weighted towards those that have a glyph.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 9));
      1: return 8'($urandom_range(8'h30, 8'h39));
      2: return 8'($urandom_range(8'h41, 8'h5A));
      3: return 8'($urandom_range(8'h61, 8'h7A));
      4: begin
        case ($urandom_range(0, 9))
          0: return 8'h22;
          1: return 8'h27;
          2: return 8'h3A;
          3: return 8'h3B;
          4: return 8'h3D;
          5: return 8'h2D;
          6: return 8'h5F;
          7: return 8'h28;
          8: return 8'h29;
          default: return 8'h2A;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Values mostly in the range of the kind, with a share that saturates or
  // falls out of range.
  function automatic logic [16:0] pick_value(req_kind_e kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      REQ_TIME:
        return 17'((r < 85) ? $urandom_range(0, 86399) : $urandom_range(86400, 131071));
      REQ_INT:
        return 17'((r < 80) ? $urandom_range(0, 65535) : $urandom_range(65536, 131071));
      REQ_ERR:
        return 17'((r < 70) ? $urandom_range(0, 99) : $urandom_range(100, 131071));
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  // Offers one item, after a random gap, and returns at the edge that takes it.
  // Valid stays high on return so that the next item can follow at once.
  task automatic send_request(req_kind_e kind, logic [16:0] value, logic [4:0][7:0] chars,
                              logic colon, logic green, logic red);
    int n;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, red, green, colon, chars, value};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every expected frame has come back and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_hour_form(logic h24);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= h24;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: runs of ready and stalls, steady stretches, one long hold-off.
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (steady) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    req_kind_e kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part in 24-hour form: time extremes and saturation, integer
    // extremes, error codes around 99, and character codes with and
    // without a glyph.
    send_request(REQ_TIME, 17'd0, '0, 1'b1, 1'b1, 1'b1);
    send_request(REQ_TIME, 17'd86399, '0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd131071, '1, 1'b1, 1'b1, 1'b1);
    send_request(REQ_TIME, 17'd45296, '0, 1'b1, 1'b0, 1'b1);
    send_request(REQ_INT, 17'd0, '0, 1'b0, 1'b1, 1'b0);
    send_request(REQ_INT, 17'd65535, '1, 1'b1, 1'b0, 1'b1);
    send_request(REQ_INT, 17'd131071, '0, 1'b0, 1'b1, 1'b1);
    send_request(REQ_INT, 17'd12345, '0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_ERR, 17'd0, '0, 1'b1, 1'b1, 1'b0);
    send_request(REQ_ERR, 17'd99, '0, 1'b0, 1'b1, 1'b0);
    send_request(REQ_ERR, 17'd100, '1, 1'b1, 1'b1, 1'b1);
    send_request(REQ_ERR, 17'd131071, '0, 1'b0, 1'b0, 1'b1);
    send_request(REQ_CHAR, 17'd0, {8'h41, 8'h39, 8'h30, 8'h09, 8'h00}, 1'b0, 1'b1, 1'b0);
    send_request(REQ_CHAR, 17'd131071, {8'h27, 8'h22, 8'h7A, 8'h61, 8'h5A},
                 1'b1, 1'b0, 1'b1);
    send_request(REQ_CHAR, 17'd5, {8'h5F, 8'h2D, 8'h3D, 8'h3B, 8'h3A}, 1'b0, 1'b1, 1'b1);
    send_request(REQ_CHAR, 17'd0, {8'h20, 8'hFF, 8'h2A, 8'h29, 8'h28}, 1'b1, 1'b0, 1'b0);
    send_request(REQ_CHAR, 17'd0, {8'h6D, 8'h40, 8'h2F, 8'h0A, 8'h80}, 1'b0, 1'b0, 1'b0);
    drain();

    // Twelve-hour form: midnight and noon, hour 13, blanked and kept
    // leading digits, and the saturated end of the day.
    write_hour_form(1'b0);
    send_request(REQ_TIME, 17'd0, '0, 1'b1, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd3599, '0, 1'b0, 1'b1, 1'b1);
    send_request(REQ_TIME, 17'd3600, '0, 1'b1, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd43200, '0, 1'b1, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd46800, '0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd86399, '0, 1'b1, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd36000, '0, 1'b1, 1'b0, 1'b0);
    send_request(REQ_TIME, 17'd131071, '0, 1'b1, 1'b0, 1'b0);
    drain();

    // Random part in phases, the hour form changed between them.
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) write_hour_form(1'b1);
      else if (p == 1) write_hour_form(1'b0);
      else write_hour_form(1'($urandom_range(0, 1)));
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        if (p == 2 && k == 0) begin
          // Keep offering back to back while the receiver holds off.
          steady   = 1'b1;
          hold_now = 1'b1;
        end
        kind = req_kind_e'($urandom_range(0, 3));
        send_request(kind, pick_value(kind),
                     {pick_char(), pick_char(), pick_char(), pick_char(), pick_char()},
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
      steady = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
